>>> rtl/core/pulse_width_symbol_decoder_defines.svh
// ----------------------------------------------------------------------------
// Pulse width symbol decoder: assertion macros
// Shared check forms for the decoder, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_SYMBOL_DECODER_DEFINES_SVH
`define PULSE_WIDTH_SYMBOL_DECODER_DEFINES_SVH

// same-cycle implication
`define PWSD_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define PWSD_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> rtl/core/pwsd_pkg.sv
// ----------------------------------------------------------------------------
// Pulse width symbol decoder package
// Constants, register indexes, symbol codes and shared types.
// ----------------------------------------------------------------------------
package pwsd_pkg;

  localparam int STAMP_W       = 20;
  localparam int STAMP_MODULUS = 1000000;
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;
  localparam int COUNT_W       = 8;
  localparam int BOUND_W       = STAMP_W + 1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_WIDTH       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ONE_WIDTH        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_WIDTH       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH_MARGIN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BYTES_TO_RECEIVE = 3'd4;

  localparam logic [STAMP_W-1:0] RST_ZERO_WIDTH   = 20'd333;
  localparam logic [STAMP_W-1:0] RST_ONE_WIDTH    = 20'd666;
  localparam logic [STAMP_W-1:0] RST_SYNC_WIDTH   = 20'd1500;
  localparam logic [STAMP_W-1:0] RST_WIDTH_MARGIN = 20'd200;
  localparam logic [COUNT_W-1:0] RST_BYTES        = 8'd18;

  localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(BITS_PER_BYTE - 1);

  typedef enum logic [1:0] {
    SYM_ZERO    = 2'd0,
    SYM_ONE     = 2'd1,
    SYM_SYNC    = 2'd2,
    SYM_UNKNOWN = 2'd3
  } symbol_t;

  typedef struct packed {
    logic [BOUND_W-1:0] zero;
    logic [BOUND_W-1:0] one;
    logic [BOUND_W-1:0] sync;
  } bounds_t;

endpackage

>>> rtl/core/pwsd_classify.sv
// ----------------------------------------------------------------------------
// Pulse width classifier
// Measures the high time modulo the stamp range and maps it to a symbol.
// ----------------------------------------------------------------------------
module pwsd_classify (
  input  logic [pwsd_pkg::STAMP_W-1:0] fall_stamp,
  input  logic [pwsd_pkg::STAMP_W-1:0] rise_stamp,
  input  pwsd_pkg::bounds_t            bounds,
  output pwsd_pkg::symbol_t            symbol
);

  localparam logic [pwsd_pkg::BOUND_W-1:0] MOD_EXT =
    pwsd_pkg::BOUND_W'(pwsd_pkg::STAMP_MODULUS);

  logic [pwsd_pkg::BOUND_W-1:0] now_ext;
  logic [pwsd_pkg::BOUND_W-1:0] then_ext;
  logic [pwsd_pkg::BOUND_W-1:0] width;

  assign now_ext  = {1'b0, fall_stamp};
  assign then_ext = {1'b0, rise_stamp};

  always_comb begin
    if (now_ext >= then_ext) begin
      width = now_ext - then_ext;
    end else begin
      width = now_ext + MOD_EXT - then_ext;
    end
    if (width < bounds.zero) begin
      symbol = pwsd_pkg::SYM_ZERO;
    end else if (width < bounds.one) begin
      symbol = pwsd_pkg::SYM_ONE;
    end else if (width < bounds.sync) begin
      symbol = pwsd_pkg::SYM_SYNC;
    end else begin
      symbol = pwsd_pkg::SYM_UNKNOWN;
    end
  end

endmodule

>>> rtl/core/pulse_width_symbol_decoder.sv
// ----------------------------------------------------------------------------
// Pulse width symbol decoder
// Edge detect, pulse measure, symbol classify and byte count on a sampled line.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one line sample per word: level and a microsecond stamp
//   that wraps at one million. m_* carries one word per measured high pulse
//   (a falling edge after some rising edge): symbol, byte-complete flag,
//   byte count and finished flag. Other samples give no output word.
//   Registers are loaded via cfg_wr/cfg_addr/cfg_data; the user must do so
//   only while idle, as the block does not enforce it. The input register
//   feeds the classify and count result to the output register. Throughput
//   is one sample per cycle unless m_tready stalls the single output register.
//   When m_tready is low and a result is held, the input register holds its
//   sample, whether or not it makes a result, and s_tready drops once the
//   input register is also full.
//   Reset clears edge state, counters, the finished flag and the valid flags of
//   both pipeline registers and restores the register defaults. Once finished,
//   samples are accepted and dropped until the next reset.
// ----------------------------------------------------------------------------
`include "pulse_width_symbol_decoder_defines.svh"

module pulse_width_symbol_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [0] line_level, [20:1] time_us, [23:21] zero
  input  logic [pwsd_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [1:0] symbol, [2] byte_complete, [10:3] bytes_done, [11] finished,
  // [15:12] zero
  output logic [pwsd_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_wr,
  input  logic [pwsd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pwsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [pwsd_pkg::STAMP_W-1:0] MOD_STAMP =
    pwsd_pkg::STAMP_W'(pwsd_pkg::STAMP_MODULUS);

  logic [pwsd_pkg::STAMP_W-1:0]   zero_width;
  logic [pwsd_pkg::STAMP_W-1:0]   one_width;
  logic [pwsd_pkg::STAMP_W-1:0]   sync_width;
  logic [pwsd_pkg::STAMP_W-1:0]   width_margin;
  logic [pwsd_pkg::COUNT_W-1:0]   bytes_to_receive;
  pwsd_pkg::bounds_t              bounds;

  logic                           in_valid;
  logic                           in_level;
  logic [pwsd_pkg::STAMP_W-1:0]   in_stamp;
  logic [pwsd_pkg::STAMP_W-1:0]   raw_stamp;
  logic [pwsd_pkg::STAMP_W-1:0]   wrap_stamp;

  logic                           prev_level;
  logic                           prev_valid;
  logic [pwsd_pkg::STAMP_W-1:0]   rise_stamp;
  logic                           rise_seen;
  logic [pwsd_pkg::BIT_CNT_W-1:0] bit_counter;
  logic [pwsd_pkg::COUNT_W-1:0]   byte_counter;
  logic                           done_flag;

  logic                           advance;
  logic                           take;
  logic                           rising;
  logic                           falling;
  logic                           emit;
  logic                           is_bit;
  logic                           complete;
  logic [pwsd_pkg::BIT_CNT_W-1:0] bit_counter_next;
  logic [pwsd_pkg::COUNT_W-1:0]   byte_counter_next;
  logic                           finish_next;
  pwsd_pkg::symbol_t              symbol;

  assign raw_stamp  = s_tdata[pwsd_pkg::STAMP_W:1];
  assign wrap_stamp = (raw_stamp >= MOD_STAMP) ? raw_stamp - MOD_STAMP : raw_stamp;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign take     = in_valid && advance;

  pwsd_classify u_classify (
    .fall_stamp (in_stamp),
    .rise_stamp (rise_stamp),
    .bounds     (bounds),
    .symbol     (symbol)
  );

  always_comb begin
    rising   = prev_valid && !prev_level && in_level;
    falling  = prev_valid && prev_level && !in_level;
    emit     = take && !done_flag && falling && rise_seen;
    is_bit   = (symbol == pwsd_pkg::SYM_ZERO) || (symbol == pwsd_pkg::SYM_ONE);
    complete = is_bit && (bit_counter == pwsd_pkg::BIT_LAST);
    if (!is_bit) begin
      bit_counter_next = bit_counter;
    end else if (complete) begin
      bit_counter_next = '0;
    end else begin
      bit_counter_next = bit_counter + pwsd_pkg::BIT_CNT_W'(1);
    end
    byte_counter_next = byte_counter + pwsd_pkg::COUNT_W'(complete);
    finish_next       = (byte_counter_next == bytes_to_receive);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_width       <= pwsd_pkg::RST_ZERO_WIDTH;
      one_width        <= pwsd_pkg::RST_ONE_WIDTH;
      sync_width       <= pwsd_pkg::RST_SYNC_WIDTH;
      width_margin     <= pwsd_pkg::RST_WIDTH_MARGIN;
      bytes_to_receive <= pwsd_pkg::RST_BYTES;
      bounds.zero <= {1'b0, pwsd_pkg::RST_ZERO_WIDTH} + {1'b0, pwsd_pkg::RST_WIDTH_MARGIN};
      bounds.one  <= {1'b0, pwsd_pkg::RST_ONE_WIDTH} + {1'b0, pwsd_pkg::RST_WIDTH_MARGIN};
      bounds.sync <= {1'b0, pwsd_pkg::RST_SYNC_WIDTH} + {1'b0, pwsd_pkg::RST_WIDTH_MARGIN};
    end else begin
      bounds.zero <= {1'b0, zero_width} + {1'b0, width_margin};
      bounds.one  <= {1'b0, one_width} + {1'b0, width_margin};
      bounds.sync <= {1'b0, sync_width} + {1'b0, width_margin};
      if (cfg_wr) begin
        case (cfg_addr)
          pwsd_pkg::CFG_ZERO_WIDTH:       zero_width       <= cfg_data;
          pwsd_pkg::CFG_ONE_WIDTH:        one_width        <= cfg_data;
          pwsd_pkg::CFG_SYNC_WIDTH:       sync_width       <= cfg_data;
          pwsd_pkg::CFG_WIDTH_MARGIN:     width_margin     <= cfg_data;
          pwsd_pkg::CFG_BYTES_TO_RECEIVE: bytes_to_receive <= cfg_data[pwsd_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      prev_level   <= 1'b0;
      prev_valid   <= 1'b0;
      rise_stamp   <= '0;
      rise_seen    <= 1'b0;
      bit_counter  <= '0;
      byte_counter <= '0;
      done_flag    <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (take && !done_flag) begin
        prev_level <= in_level;
        prev_valid <= 1'b1;
        if (rising) begin
          rise_stamp <= in_stamp;
          rise_seen  <= 1'b1;
        end
      end
      if (emit) begin
        bit_counter  <= bit_counter_next;
        byte_counter <= byte_counter_next;
        done_flag    <= finish_next;
      end
      if (advance) begin
        m_tvalid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_level <= s_tdata[0];
      in_stamp <= wrap_stamp;
    end
    if (emit) begin
      m_tdata <= {4'b0, finish_next, byte_counter_next, complete, symbol};
    end
  end

  `PWSD_ASSERT_NOW(a_finished_sets_done, m_tvalid && m_tdata[11], done_flag,
    "finished result without done flag")
  `PWSD_ASSERT_NEXT(a_no_result_after_done, done_flag && m_tvalid && m_tready, !m_tvalid,
    "result produced after reception finished")
  `PWSD_ASSERT_NOW(a_complete_is_bit, m_tvalid && m_tdata[2],
    m_tdata[1:0] == pwsd_pkg::SYM_ZERO || m_tdata[1:0] == pwsd_pkg::SYM_ONE,
    "byte completed by a non-data symbol")

endmodule
